FILE: rtl/sm4_pkg.sv
// sm4_pkg: shared constants, S-box table and round-constant helper for the SM4 cipher
// used by the round unit and the top-level sequencer; depends on nothing
`timescale 1ns / 1ps

package sm4_pkg;

   // round key store geometry
   localparam int RK_COUNT  = 32;
   localparam int RK_ADDR_W = 5;
   localparam int WORD_W    = 32;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd1;

   // system parameter words for key whitening
   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // byte-wise S-box substitution of one word
   function automatic logic [31:0] sbox_word(input logic [31:0] v);
      sbox_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // key schedule constant: byte j of word i is (4*i + j) * 7 mod 256
   function automatic logic [31:0] ck_word(input logic [RK_ADDR_W-1:0] idx);
      logic [7:0]  base;
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         base = {1'b0, idx, 2'(j)};
         w = {w[23:0], 8'((base << 3) - base)};
      end
      ck_word = w;
   endfunction

endpackage

FILE: rtl/sm4_stream_if.sv
// sm4_stream_if: valid/ready channel interfaces for requests and results of the SM4 block
// payload widths are fixed by the cipher block size; no package dependency
`timescale 1ns / 1ps

interface sm4_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_high;
   logic [63:0] data_low;
   logic        decrypt;

   modport source (output valid, output data_high, output data_low, output decrypt,
                   input ready);
   modport sink   (input valid, input data_high, input data_low, input decrypt,
                   output ready);
endinterface

interface sm4_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;

   modport source (output valid, output result_high, output result_low, input ready);
   modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

FILE: rtl/sm4_block_cipher.sv
// sm4_block_cipher: SM4 engine, one round per cycle through one shared round unit
// requests are taken only when idle; stale keys are expanded first, then prime, rounds, drain
// no new request is taken before the result is loaded into the output register
// reset: synchronous, clears the key registers and marks the round keys stale
// the round key RAM is not cleared; the first request after reset expands the all-zero key
// depends on sm4_pkg, sm4_stream_if, sm4_ram and sm4_feistel_unit
`timescale 1ns / 1ps

module sm4_block_cipher (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [sm4_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sm4_pkg::CSR_DATA_W-1:0]       csr_wdata,
   sm4_req_if.sink                              req_bus,
   sm4_rsp_if.source                            rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_PRIME,
      ST_ROUND,
      ST_DRAIN
   } state_type;

   localparam logic [sm4_pkg::RK_ADDR_W-1:0] LAST_ROUND =
      sm4_pkg::RK_ADDR_W'(sm4_pkg::RK_COUNT - 1);

   state_type                       state_ff, state_in;
   logic [sm4_pkg::RK_ADDR_W-1:0]   cnt_ff, cnt_in;
   logic                            keys_current_ff, keys_current_in;
   logic [63:0]                     key_high_ff, key_high_in;
   logic [63:0]                     key_low_ff, key_low_in;
   logic [63:0]                     data_high_ff, data_high_in;
   logic [63:0]                     data_low_ff, data_low_in;
   logic                            decrypt_ff, decrypt_in;
   logic [31:0]                     w0_ff, w1_ff, w2_ff, w3_ff;
   logic [31:0]                     w0_in, w1_in, w2_in, w3_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [63:0]                     rsp_high_ff, rsp_high_in;
   logic [63:0]                     rsp_low_ff, rsp_low_in;

   logic                            req_accept;
   logic                            key_mode;
   logic [31:0]                     round_key;
   logic [31:0]                     nx;
   logic                            ram_we;
   logic [sm4_pkg::RK_ADDR_W-1:0]   ram_raddr;
   logic [31:0]                     ram_rdata;
   logic [sm4_pkg::RK_ADDR_W-1:0]   cnt_next;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign req_accept      = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.result_high = rsp_high_ff;
   assign rsp_bus.result_low  = rsp_low_ff;

   assign cnt_next = sm4_pkg::RK_ADDR_W'(cnt_ff + 1'b1);

   // round key source: schedule constant while expanding, stored key while ciphering
   assign key_mode  = (state_ff == ST_EXPAND);
   assign round_key = key_mode ? sm4_pkg::ck_word(cnt_ff) : ram_rdata;
   assign ram_we    = key_mode;

   // read address runs one round ahead, mirrored for decryption
   always_comb begin
      if (state_ff == ST_ROUND) begin
         ram_raddr = decrypt_ff ? ~cnt_next : cnt_next;
      end else begin
         ram_raddr = decrypt_ff ? ~'0 : '0;
      end
   end

   sm4_feistel_unit u_round (
      .key_mode (key_mode),
      .x0       (w0_ff),
      .x1       (w1_ff),
      .x2       (w2_ff),
      .x3       (w3_ff),
      .rk       (round_key),
      .nx       (nx)
   );

   sm4_ram #(
      .WIDTH (sm4_pkg::WORD_W),
      .DEPTH (sm4_pkg::RK_COUNT)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff),
      .wr_data (nx),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer next-state logic
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      keys_current_in = keys_current_ff;
      key_high_in     = key_high_ff;
      key_low_in      = key_low_ff;
      data_high_in    = data_high_ff;
      data_low_in     = data_low_ff;
      decrypt_in      = decrypt_ff;
      w0_in           = w0_ff;
      w1_in           = w1_ff;
      w2_in           = w2_ff;
      w3_in           = w3_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_high_in     = rsp_high_ff;
      rsp_low_in      = rsp_low_ff;

      // key register writes mark the round keys stale
      if (csr_wr_en) begin
         case (csr_index)
            sm4_pkg::CSR_KEY_HIGH: begin
               key_high_in     = csr_wdata;
               keys_current_in = 1'b0;
            end
            sm4_pkg::CSR_KEY_LOW: begin
               key_low_in      = csr_wdata;
               keys_current_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               data_high_in = req_bus.data_high;
               data_low_in  = req_bus.data_low;
               decrypt_in   = req_bus.decrypt;
               cnt_in       = '0;
               if (keys_current_ff) begin
                  w0_in    = req_bus.data_high[63:32];
                  w1_in    = req_bus.data_high[31:0];
                  w2_in    = req_bus.data_low[63:32];
                  w3_in    = req_bus.data_low[31:0];
                  state_in = ST_PRIME;
               end else begin
                  w0_in    = key_high_ff[63:32] ^ sm4_pkg::FK0;
                  w1_in    = key_high_ff[31:0]  ^ sm4_pkg::FK1;
                  w2_in    = key_low_ff[63:32]  ^ sm4_pkg::FK2;
                  w3_in    = key_low_ff[31:0]   ^ sm4_pkg::FK3;
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            w0_in  = w1_ff;
            w1_in  = w2_ff;
            w2_in  = w3_ff;
            w3_in  = nx;
            cnt_in = cnt_next;
            if (cnt_ff == LAST_ROUND) begin
               keys_current_in = 1'b1;
               w0_in    = data_high_ff[63:32];
               w1_in    = data_high_ff[31:0];
               w2_in    = data_low_ff[63:32];
               w3_in    = data_low_ff[31:0];
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            w0_in  = w1_ff;
            w1_in  = w2_ff;
            w2_in  = w3_ff;
            w3_in  = nx;
            cnt_in = cnt_next;
            if (cnt_ff == LAST_ROUND) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // final word reversal into the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_high_in  = {w3_ff, w2_ff};
               rsp_low_in   = {w1_ff, w0_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         keys_current_ff <= 1'b0;
         key_high_ff     <= '0;
         key_low_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         keys_current_ff <= keys_current_in;
         key_high_ff     <= key_high_in;
         key_low_ff      <= key_low_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      data_high_ff <= data_high_in;
      data_low_ff  <= data_low_in;
      decrypt_ff   <= decrypt_in;
      w0_ff        <= w0_in;
      w1_ff        <= w1_in;
      w2_ff        <= w2_in;
      w3_ff        <= w3_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_low_ff   <= rsp_low_in;
   end

`ifndef SYNTHESIS
   // a request with stale keys starts the key expansion
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !keys_current_ff && !csr_wr_en |=> state_ff == ST_EXPAND)
      else $error("stale keys did not start expansion");

   // round keys become current only at the end of an expansion
   assert property (@(posedge clock) disable iff (reset)
      $rose(keys_current_ff) |-> $past(state_ff) == ST_EXPAND && $past(cnt_ff) == LAST_ROUND)
      else $error("keys marked current outside expansion");

   // a key write leaves the round keys stale
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && (csr_index == sm4_pkg::CSR_KEY_HIGH || csr_index == sm4_pkg::CSR_KEY_LOW)
      |=> !keys_current_ff)
      else $error("key write did not invalidate round keys");

   // a new result is only loaded from the drain step after the last round
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DRAIN)
      else $error("result loaded outside drain");
`endif

endmodule

FILE: rtl/sm4_ram.sv
// sm4_ram: generic single-write, single-read RAM with registered read data
// stand-alone; holds the round keys of the SM4 block
`timescale 1ns / 1ps

module sm4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/sm4_round.sv
// sm4_feistel_unit: shared SM4 round function x0 ^ T(x1 ^ x2 ^ x3 ^ k), with L or key-schedule L'
// depends on sm4_pkg for the S-box
`timescale 1ns / 1ps

module sm4_feistel_unit (
   input  logic        key_mode,
   input  logic [31:0] x0,
   input  logic [31:0] x1,
   input  logic [31:0] x2,
   input  logic [31:0] x3,
   input  logic [31:0] rk,
   output logic [31:0] nx
);

   logic [31:0] b;
   logic [31:0] lin;

   // nonlinear layer
   assign b = sm4_pkg::sbox_word(x1 ^ x2 ^ x3 ^ rk);

   // linear layer, cipher or key schedule form
   always_comb begin
      if (key_mode) begin
         lin = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
      end else begin
         lin = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
      end
   end

   assign nx = x0 ^ lin;

endmodule

FILE: test/tb_sm4_block_cipher.sv
// tb_sm4_block_cipher: self-checking regression for the SM4 engine, directed table then random
// blocks under changing keys and idle patterns; needs sm4_pkg, sm4_stream_if and the RTL
`timescale 1ns / 1ps

module tb_sm4_block_cipher;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int TAIL_CYCLES     = 70;
   localparam int ITEMS_PER_PHASE = 380;
   localparam int N_PHASES        = 5;
   localparam int N_DIRECTED      = 19;

   // indexes past key_low decode to nothing
   localparam logic [sm4_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sm4_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   // key whitening words
   localparam logic [31:0] WHITEN_0 = 32'ha3b1bac6;
   localparam logic [31:0] WHITEN_1 = 32'h56aa3350;
   localparam logic [31:0] WHITEN_2 = 32'h677d9197;
   localparam logic [31:0] WHITEN_3 = 32'hb27022dc;

   localparam logic [7:0] SUBST_TABLE [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } block128_type;

   typedef enum logic [1:0] {STEP_WRITE, STEP_BLOCK, STEP_BLOCK_KNOWN} step_kind_type;

   // word_high carries the write data on register rows
   typedef struct packed {
      step_kind_type                       kind;
      logic [sm4_pkg::CSR_INDEX_W-1:0]     sel;
      logic [63:0]                         word_high;
      logic [63:0]                         word_low;
      logic                                decrypt;
      block128_type                        known;
   } dir_step_type;

   localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] STD_HIGH = 64'h0123456789abcdef;
   localparam logic [63:0] STD_LOW  = 64'hfedcba9876543210;
   localparam logic [63:0] STD_CT_HIGH = 64'h681edf34d206965e;
   localparam logic [63:0] STD_CT_LOW  = 64'h86b3e94f536e4246;

   // directed table: reset key, ignored indexes, standard vector, key extremes
   dir_step_type directed_steps [N_DIRECTED] = '{
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, 64'h0,    64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, ONES,     ONES,     1'b1, '0},
      '{STEP_WRITE,       CSR_SPARE_2,           ONES,     64'h0,    1'b0, '0},
      '{STEP_WRITE,       CSR_SPARE_3,           ONES,     64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, STD_HIGH, STD_LOW,  1'b0, '0},
      '{STEP_WRITE,       sm4_pkg::CSR_KEY_HIGH, STD_HIGH, 64'h0,    1'b0, '0},
      '{STEP_WRITE,       sm4_pkg::CSR_KEY_LOW,  STD_LOW,  64'h0,    1'b0, '0},
      '{STEP_BLOCK_KNOWN, sm4_pkg::CSR_KEY_HIGH, STD_HIGH, STD_LOW,  1'b0,
        {STD_CT_HIGH, STD_CT_LOW}},
      '{STEP_BLOCK_KNOWN, sm4_pkg::CSR_KEY_HIGH, STD_CT_HIGH, STD_CT_LOW, 1'b1,
        {STD_HIGH, STD_LOW}},
      '{STEP_BLOCK_KNOWN, sm4_pkg::CSR_KEY_HIGH, STD_HIGH, STD_LOW,  1'b0,
        {STD_CT_HIGH, STD_CT_LOW}},
      '{STEP_WRITE,       sm4_pkg::CSR_KEY_HIGH, ONES,     64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, ONES,     ONES,     1'b0, '0},
      '{STEP_WRITE,       sm4_pkg::CSR_KEY_LOW,  ONES,     64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, 64'h0,    64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, ONES,     ONES,     1'b1, '0},
      '{STEP_WRITE,       sm4_pkg::CSR_KEY_HIGH, 64'h0,    64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, {4{16'h5555}}, {4{16'haaaa}}, 1'b0, '0},
      '{STEP_WRITE,       sm4_pkg::CSR_KEY_LOW,  64'h0,    64'h0,    1'b0, '0},
      '{STEP_BLOCK,       sm4_pkg::CSR_KEY_HIGH, {4{16'haaaa}}, {4{16'h5555}}, 1'b1, '0}
   };

   logic                                clock;
   logic                                reset;
   logic                                csr_wr_en;
   logic [sm4_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [sm4_pkg::CSR_DATA_W-1:0]      csr_wdata;

   sm4_req_if req_bus ();
   sm4_rsp_if rsp_bus ();

   sm4_block_cipher uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // cipher model state, mirrors the key registers and the round key store
   logic [63:0] model_key_high = '0;
   logic [63:0] model_key_low  = '0;
   logic [31:0] model_rk [32];
   logic        model_rk_fresh = 1'b0;

   block128_type cipher_out_q [$];
   block128_type last_out;
   bit          have_last = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] v);
      return {SUBST_TABLE[v[31:24]], SUBST_TABLE[v[23:16]],
              SUBST_TABLE[v[15:8]], SUBST_TABLE[v[7:0]]};
   endfunction

   // data path transform: s-box then L
   function automatic logic [31:0] data_mix(input logic [31:0] v);
      logic [31:0] b;
      b = subst_word(v);
      return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
   endfunction

   // key schedule transform: s-box then L'
   function automatic logic [31:0] key_mix(input logic [31:0] v);
      logic [31:0] b;
      b = subst_word(v);
      return b ^ rotl32(b, 13) ^ rotl32(b, 23);
   endfunction

   // round constant, byte j of word i is (4i+j)*7 mod 256
   function automatic logic [31:0] round_const(input int unsigned i);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++)
         w = {w[23:0], 8'(((4 * i + j) * 7) & 255)};
      return w;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] k0, k1, k2, k3, nk;
      k0 = model_key_high[63:32] ^ WHITEN_0;
      k1 = model_key_high[31:0]  ^ WHITEN_1;
      k2 = model_key_low[63:32]  ^ WHITEN_2;
      k3 = model_key_low[31:0]   ^ WHITEN_3;
      for (int i = 0; i < 32; i++) begin
         nk = k0 ^ key_mix(k1 ^ k2 ^ k3 ^ round_const(i));
         model_rk[i] = nk;
         k0 = k1;
         k1 = k2;
         k2 = k3;
         k3 = nk;
      end
      model_rk_fresh = 1'b1;
   endfunction

   // 32 rounds then word reversal; decrypt walks the round keys backward
   function automatic block128_type sm4_transform(input logic [63:0] hi, input logic [63:0] lo,
                                                  input logic dec);
      logic [31:0]  x0, x1, x2, x3, nx, rk;
      block128_type r;
      if (!model_rk_fresh)
         expand_round_keys();
      x0 = hi[63:32];
      x1 = hi[31:0];
      x2 = lo[63:32];
      x3 = lo[31:0];
      for (int i = 0; i < 32; i++) begin
         rk = dec ? model_rk[31 - i] : model_rk[i];
         nx = x0 ^ data_mix(x1 ^ x2 ^ x3 ^ rk);
         x0 = x1;
         x1 = x2;
         x2 = x3;
         x3 = nx;
      end
      r.high = {x3, x2};
      r.low  = {x1, x0};
      return r;
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(15))
         0:       return 64'h0;
         1:       return ONES;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // offer one request, predict it once accepted; valid stays up for back-to-back
   task automatic push_request(input logic [63:0] hi, input logic [63:0] lo, input logic dec,
                               input bit use_known, input block128_type known);
      block128_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_high <= {$urandom(), $urandom()};
         req_bus.data_low  <= {$urandom(), $urandom()};
         req_bus.decrypt   <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_high <= hi;
      req_bus.data_low  <= lo;
      req_bus.decrypt   <= dec;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      pred = sm4_transform(hi, lo, dec);
      cipher_out_q.push_back(use_known ? known : pred);
      last_out  = pred;
      have_last = 1'b1;
   endtask

   // hold off requests until every outstanding result is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (cipher_out_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [sm4_pkg::CSR_INDEX_W-1:0] sel,
                            input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         sm4_pkg::CSR_KEY_HIGH: begin
            model_key_high = value;
            model_rk_fresh = 1'b0;
         end
         sm4_pkg::CSR_KEY_LOW: begin
            model_key_low  = value;
            model_rk_fresh = 1'b0;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               cipher_out_q.size());
      $display("sm4_block_cipher regression: fail");
      $finish;
   end

   // result side: random stalls and compare against the oldest prediction
   always @(posedge clock) begin : result_check
      block128_type want;
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cipher_out_q.size() == 0) begin
            $display("%0t: result with no request outstanding, got %h %h", $time,
                     rsp_bus.result_high, rsp_bus.result_low);
            mismatch_count++;
         end else begin
            want = cipher_out_q.pop_front();
            if (rsp_bus.result_high !== want.high) begin
               $display("%0t: result_high mismatch, expected %h, actual %h", $time,
                        want.high, rsp_bus.result_high);
               mismatch_count++;
            end
            if (rsp_bus.result_low !== want.low) begin
               $display("%0t: result_low mismatch, expected %h, actual %h", $time,
                        want.low, rsp_bus.result_low);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      dir_step_type s;
      int unsigned  sent;
      int unsigned  group;
      int unsigned  pick;
      logic [63:0]  hi, lo;
      logic         dec;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_high = '0;
      req_bus.data_low  = '0;
      req_bus.decrypt   = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      send_idle_pct = 20;
      stall_pct     = 20;
      for (int i = 0; i < N_DIRECTED; i++) begin
         s = directed_steps[i];
         if (s.kind == STEP_WRITE) begin
            drain_results();
            write_csr(s.sel, s.word_high);
         end else begin
            push_request(s.word_high, s.word_low, s.decrypt, s.kind == STEP_BLOCK_KNOWN,
                         s.known);
         end
      end

      // random phases: none, sender idle, receiver stall, both, bursty
      for (int phase = 0; phase < N_PHASES; phase++) begin
         drain_results();
         write_csr(sm4_pkg::CSR_KEY_HIGH, pick_word());
         write_csr(sm4_pkg::CSR_KEY_LOW, pick_word());
         send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 36 : 0;
         stall_pct     = (phase == 2) ? 80 : (phase == 3) ? 36 : 0;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            group = $urandom_range(4, 40);
            if (phase == 4) begin
               send_idle_pct = $urandom_range(1) ? 0 : $urandom_range(10, 90);
               stall_pct     = $urandom_range(1) ? 0 : $urandom_range(10, 90);
            end
            repeat (group) begin
               pick = $urandom_range(99);
               if (have_last && pick < 20) begin
                  // decrypt the result of the previous request
                  hi  = last_out.high;
                  lo  = last_out.low;
                  dec = 1'b1;
               end else if (have_last && pick < 28) begin
                  hi  = last_out.high;
                  lo  = last_out.low;
                  dec = 1'b0;
               end else begin
                  hi  = pick_word();
                  lo  = pick_word();
                  dec = 1'($urandom_range(1));
               end
               push_request(hi, lo, dec, 1'b0, '0);
               sent++;
            end
            // key changes only with the engine idle
            drain_results();
            case ($urandom_range(7))
               3:       write_csr(sm4_pkg::CSR_KEY_HIGH, pick_word());
               4:       write_csr(sm4_pkg::CSR_KEY_LOW, pick_word());
               5, 6: begin
                  write_csr(sm4_pkg::CSR_KEY_HIGH, pick_word());
                  write_csr(sm4_pkg::CSR_KEY_LOW, pick_word());
               end
               7:       write_csr($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3, pick_word());
               default: ;
            endcase
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("sm4_block_cipher regression: pass");
      else
         $display("sm4_block_cipher regression: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/sm4_pkg.sv
rtl/sm4_stream_if.sv
rtl/sm4_ram.sv
rtl/sm4_round.sv
rtl/sm4_block_cipher.sv
test/tb_sm4_block_cipher.sv
